[src/slc_pkg.sv]
// slc_pkg: shared types, codes and constants of the sorted list engine
// no dependencies; used by the interfaces, the cell, the top level and the checker
package slc_pkg;

  // default number of stored values and the read-out cap
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 16;

  // field widths
  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE_ONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READOUT    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMALL,
    ST_EMIT,
    ST_RESTORE
  } slc_state_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } slc_cell_op_e;

  // broadcast control to the row of cells
  typedef struct packed {
    slc_cell_op_e             op;
    logic signed [VAL_W-1:0]  key;
    logic                     incl;
  } slc_ctrl_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic valid;
    logic tail;
  } slc_pos_t;

  // compare results of one cell against the key
  typedef struct packed {
    logic gt;
    logic ge;
    logic eq;
    logic qual;
  } slc_flags_t;

endpackage

[src/slc_cmd_if.sv]
// slc_cmd_if: command channel, valid/ready handshake with the command payload
// depends on slc_pkg for field widths
interface slc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [slc_pkg::KIND_W-1:0]       kind;
  logic signed [slc_pkg::VAL_W-1:0] operand_value;
  logic                             include_limit;

  modport source (output valid, kind, operand_value, include_limit, input ready);
  modport sink   (input valid, kind, operand_value, include_limit, output ready);
endinterface

[src/slc_res_if.sv]
// slc_res_if: result channel, valid/ready handshake with the result payload
// depends on slc_pkg for field widths
interface slc_res_if;
  logic                             valid;
  logic                             ready;
  logic [slc_pkg::STATUS_W-1:0]     status;
  logic signed [slc_pkg::VAL_W-1:0] item_value;
  logic                             has_item;
  logic [slc_pkg::COUNT_W-1:0]      entry_count;
  logic                             is_last;

  modport source (output valid, status, item_value, has_item, entry_count, is_last,
                  input ready);
  modport sink   (input valid, status, item_value, has_item, entry_count, is_last,
                  output ready);
endinterface

[src/sorted_list_engine.sv]
// sorted_list_engine: top level, row of slc_cell slots plus the command sequencer
// depends on slc_pkg, slc_cmd_if, slc_res_if and slc_cell
//
// Usage
// - cmd_i carries one command per beat: insert, remove first, remove all, clear,
//   or read out stored values below a limit (or up to it when include_limit), at most MAX_RESULTS.
// - res_o carries results through one output register. Insert, remove first,
//   clear and unused codes give one beat, in the cycle after the command beat; such
//   commands can be taken every cycle while the receiver keeps up.
// - remove all shifts out one match per cycle, then gives its single result beat
//   once no match is left.
// - a read-out rotates the chain one slot per cycle while the receiver keeps up and
//   shows the head slot as a result beat, so values come one per cycle; after the
//   last one the chain keeps rotating until it is back in place. A read-out
//   occupies the block until then; with nothing to show, one empty beat.
// - the sequencer takes a command only when idle and the output register is
//   free or drained in the same cycle; a stalled receiver stops the chain while it shows values.
// - reset empties the store (occupancy zero); slot contents are not cleared and
//   are never read before they are written.
module sorted_list_engine #(
  parameter int CAPACITY = slc_pkg::CAPACITY_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  slc_cmd_if.sink     cmd_i,
  slc_res_if.source   res_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  slc_pkg::slc_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       rot_q, rot_d;
  logic                any_q, any_d;
  logic signed [slc_pkg::VAL_W-1:0] v_q;
  logic                incl_q;

  // result register
  logic                                res_valid_q;
  logic [slc_pkg::STATUS_W-1:0]        res_status_q, res_status_d;
  logic signed [slc_pkg::VAL_W-1:0]    res_value_q, res_value_d;
  logic                                res_has_q, res_has_d;
  logic [slc_pkg::COUNT_W-1:0]         res_count_q, res_count_d;
  logic                                res_last_q, res_last_d;
  logic                                ld_res;

  slc_pkg::slc_ctrl_t                ctrl;
  slc_pkg::slc_cell_op_e             cell_op;
  logic signed [slc_pkg::VAL_W-1:0]  cell_val [CAPACITY];
  slc_pkg::slc_flags_t               flags [CAPACITY];
  logic [CAPACITY-1:0]               eq_vec;
  logic                              found;
  logic                              slot_free;
  logic                              cmd_fire;
  logic                              emit_last;

  assign slot_free = !res_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == slc_pkg::ST_IDLE) && slot_free;
  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign found = |eq_vec;

  // key comes straight from the command when idle, else from the latched command
  always_comb begin
    ctrl.op   = cell_op;
    ctrl.key  = (state_q == slc_pkg::ST_IDLE) ? cmd_i.operand_value : v_q;
    ctrl.incl = (state_q == slc_pkg::ST_IDLE) ? cmd_i.include_limit : incl_q;
  end

  // row of cells
  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [slc_pkg::VAL_W-1:0] left_v;
    logic signed [slc_pkg::VAL_W-1:0] right_v;
    logic                             left_gt;
    slc_pkg::slc_pos_t                pos;

    if (g == 0) begin : g_first
      assign left_v  = '0;
      assign left_gt = 1'b0;
    end else begin : g_inner_l
      assign left_v  = cell_val[g-1];
      assign left_gt = flags[g-1].gt;
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[g];
    end else begin : g_inner_r
      assign right_v = cell_val[g+1];
    end

    assign pos.valid = CW'(g) < count_q;
    assign pos.tail  = CW'(g + 1) == count_q;
    assign eq_vec[g] = flags[g].eq;

    slc_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .pos_i       (pos),
      .left_val_i  (left_v),
      .left_gt_i   (left_gt),
      .right_val_i (right_v),
      .wrap_val_i  (cell_val[0]),
      .val_o       (cell_val[g]),
      .flags_o     (flags[g])
    );
  end

  // read-out ends at the chain end, the first value that misses the limit, or the cap
  assign emit_last = (rot_q + CW'(1) == count_q) || !flags[1].qual ||
                     (int'(rot_q) + 1 == slc_pkg::MAX_RESULTS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slc_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd_i.kind == slc_pkg::KIND_REMOVE_ALL) begin
            state_d = slc_pkg::ST_RMALL;
          end else if (cmd_i.kind == slc_pkg::KIND_READOUT) begin
            state_d = flags[0].qual ? slc_pkg::ST_EMIT : slc_pkg::ST_RESTORE;
          end
        end
      end
      slc_pkg::ST_RMALL: begin
        if (!found && slot_free) begin
          state_d = slc_pkg::ST_IDLE;
        end
      end
      slc_pkg::ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_d = slc_pkg::ST_RESTORE;
        end
      end
      slc_pkg::ST_RESTORE: begin
        if (rot_q == count_q) begin
          state_d = slc_pkg::ST_IDLE;
        end
      end
      default: state_d = slc_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result loading
  always_comb begin
    cell_op      = slc_pkg::CELL_HOLD;
    count_d      = count_q;
    rot_d        = rot_q;
    any_d        = any_q;
    ld_res       = 1'b0;
    res_status_d = slc_pkg::STATUS_OK;
    res_value_d  = '0;
    res_has_d    = 1'b0;
    res_last_d   = 1'b1;
    case (state_q)
      slc_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd_i.kind)
            slc_pkg::KIND_INSERT: begin
              ld_res = 1'b1;
              if (count_q == CW'(CAPACITY)) begin
                res_status_d = slc_pkg::STATUS_FULL;
              end else begin
                cell_op = slc_pkg::CELL_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            slc_pkg::KIND_REMOVE_ONE: begin
              ld_res = 1'b1;
              if (found) begin
                cell_op = slc_pkg::CELL_REMOVE;
                count_d = count_q - CW'(1);
              end else begin
                res_status_d = slc_pkg::STATUS_NOT_FOUND;
              end
            end
            slc_pkg::KIND_REMOVE_ALL: begin
              any_d = 1'b0;
            end
            slc_pkg::KIND_CLEAR: begin
              ld_res  = 1'b1;
              count_d = '0;
            end
            slc_pkg::KIND_READOUT: begin
              rot_d  = '0;
              ld_res = !flags[0].qual;
            end
            default: ld_res = 1'b1;
          endcase
        end
      end
      slc_pkg::ST_RMALL: begin
        if (found) begin
          cell_op = slc_pkg::CELL_REMOVE;
          count_d = count_q - CW'(1);
          any_d   = 1'b1;
        end else if (slot_free) begin
          ld_res       = 1'b1;
          res_status_d = any_q ? slc_pkg::STATUS_OK : slc_pkg::STATUS_NOT_FOUND;
        end
      end
      slc_pkg::ST_EMIT: begin
        if (slot_free) begin
          ld_res      = 1'b1;
          res_value_d = cell_val[0];
          res_has_d   = 1'b1;
          res_last_d  = emit_last;
          cell_op     = slc_pkg::CELL_ROTATE;
          rot_d       = rot_q + CW'(1);
        end
      end
      slc_pkg::ST_RESTORE: begin
        if (rot_q != count_q) begin
          cell_op = slc_pkg::CELL_ROTATE;
          rot_d   = rot_q + CW'(1);
        end
      end
      default: cell_op = slc_pkg::CELL_HOLD;
    endcase
    res_count_d = slc_pkg::COUNT_W'(count_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slc_pkg::ST_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rot_q   <= rot_d;
      any_q   <= any_d;
      if (ld_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // latched command and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      v_q    <= cmd_i.operand_value;
      incl_q <= cmd_i.include_limit;
    end
    if (ld_res) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_has_q    <= res_has_d;
      res_count_q  <= res_count_d;
      res_last_q   <= res_last_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.item_value  = res_value_q;
  assign res_o.has_item    = res_has_q;
  assign res_o.entry_count = res_count_q;
  assign res_o.is_last     = res_last_q;

endmodule

[src/slc_cell.sv]
// slc_cell: one slot of the sorted chain, holds a value and compares it to the key
// depends on slc_pkg for the control, position and flag types
module slc_cell (
  input  logic                             clk_i,
  input  slc_pkg::slc_ctrl_t               ctrl_i,
  input  slc_pkg::slc_pos_t                pos_i,
  input  logic signed [slc_pkg::VAL_W-1:0] left_val_i,
  input  logic                             left_gt_i,
  input  logic signed [slc_pkg::VAL_W-1:0] right_val_i,
  input  logic signed [slc_pkg::VAL_W-1:0] wrap_val_i,
  output logic signed [slc_pkg::VAL_W-1:0] val_o,
  output slc_pkg::slc_flags_t              flags_o
);

  logic signed [slc_pkg::VAL_W-1:0] val_q, val_d;

  // compares against the broadcast key
  always_comb begin
    flags_o.gt   = pos_i.valid && (val_q > ctrl_i.key);
    flags_o.ge   = pos_i.valid && (val_q >= ctrl_i.key);
    flags_o.eq   = pos_i.valid && (val_q == ctrl_i.key);
    flags_o.qual = pos_i.valid && ((val_q < ctrl_i.key) ||
                                   (ctrl_i.incl && (val_q == ctrl_i.key)));
  end

  // next value from own slot, a neighbor, the key or the wrapped head value
  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      slc_pkg::CELL_INSERT: begin
        if (left_gt_i) begin
          val_d = left_val_i;
        end else if (flags_o.gt || !pos_i.valid) begin
          val_d = ctrl_i.key;
        end
      end
      slc_pkg::CELL_REMOVE: begin
        if (flags_o.ge) begin
          val_d = right_val_i;
        end
      end
      slc_pkg::CELL_ROTATE: begin
        if (pos_i.valid) begin
          val_d = pos_i.tail ? wrap_val_i : right_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[src/slc_checker.sv]
// slc_checker: port-level assertions for sorted_list_engine, attached by bind
// depends on slc_pkg for status codes and on the top level's channel ports
module slc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cmd_valid_i,
  input logic                             cmd_ready_i,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [slc_pkg::STATUS_W-1:0]     res_status_i,
  input logic signed [slc_pkg::VAL_W-1:0] res_item_value_i,
  input logic                             res_has_item_i,
  input logic [slc_pkg::COUNT_W-1:0]      res_count_i,
  input logic                             res_last_i
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i) && $stable(res_item_value_i) &&
      $stable(res_has_item_i) && $stable(res_count_i) && $stable(res_last_i))
    else $error("result payload changed while stalled");

  // no command beat is taken while a result beat is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |-> !(res_valid_i && !res_ready_i))
    else $error("command taken while result register blocked");

  // a beat without a value is always the final one and carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_has_item_i |-> res_last_i && (res_item_value_i == '0))
    else $error("empty result beat not final or nonzero");

  // read-out beats always report ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_has_item_i |-> res_status_i == slc_pkg::STATUS_OK)
    else $error("read-out beat with bad status");

endmodule

bind sorted_list_engine slc_checker u_slc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_valid_i      (cmd_i.valid),
  .cmd_ready_i      (cmd_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_status_i     (res_o.status),
  .res_item_value_i (res_o.item_value),
  .res_has_item_i   (res_o.has_item),
  .res_count_i      (res_o.entry_count),
  .res_last_i       (res_o.is_last)
);

[dv/slc_tb_pkg.sv]
// slc_tb_pkg: result type and scoreboard class for the sorted list engine bench
// depends on slc_pkg for widths, command codes and status codes
package slc_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;

  typedef logic signed [VAL_W-1:0] slc_value_t;

  // one result beat as seen on the result channel
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    slc_value_t          item_value;
    logic                has_item;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_last;
  } slc_result_t;

  // keeps its own ascending copy of the store and the beats it must produce
  class slc_scoreboard;
    int          cap;
    slc_value_t  store[$];
    slc_result_t awaited[$];
    int          errors;
    int          commands;
    int          beats;
    int          values_out;
    int          full_drops;
    int          misses;

    function new(int capacity);
      cap = capacity;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push_beat(logic [STATUS_W-1:0] status, slc_value_t item, logic has,
                            logic last);
      slc_result_t r;
      r.status      = status;
      r.item_value  = item;
      r.has_item    = has;
      r.entry_count = COUNT_W'(store.size());
      r.is_last     = last;
      awaited.push_back(r);
    endfunction

    // update the store for one accepted command and queue its beats
    function void note_command(logic [KIND_W-1:0] kind, slc_value_t value, logic incl);
      int  pos;
      int  n;
      int  idx;
      bit  found;
      commands++;
      case (kind)
        KIND_INSERT: begin
          if (store.size() >= cap) begin
            full_drops++;
            push_beat(STATUS_FULL, '0, 1'b0, 1'b1);
          end else begin
            // new value goes after any equal ones
            pos = 0;
            while (pos < store.size() && store[pos] <= value) pos++;
            store.insert(pos, value);
            push_beat(STATUS_OK, '0, 1'b0, 1'b1);
          end
        end
        KIND_REMOVE_ONE: begin
          found = 1'b0;
          for (idx = 0; idx < store.size(); idx++) begin
            if (store[idx] == value) begin
              store.delete(idx);
              found = 1'b1;
              break;
            end
          end
          if (!found) misses++;
          push_beat(found ? STATUS_OK : STATUS_NOT_FOUND, '0, 1'b0, 1'b1);
        end
        KIND_REMOVE_ALL: begin
          found = 1'b0;
          idx = 0;
          while (idx < store.size()) begin
            if (store[idx] == value) begin
              store.delete(idx);
              found = 1'b1;
            end else begin
              idx++;
            end
          end
          if (!found) misses++;
          push_beat(found ? STATUS_OK : STATUS_NOT_FOUND, '0, 1'b0, 1'b1);
        end
        KIND_CLEAR: begin
          store.delete();
          push_beat(STATUS_OK, '0, 1'b0, 1'b1);
        end
        KIND_READOUT: begin
          // ascending values below the limit, capped, last one marked
          n = 0;
          for (idx = 0; idx < store.size() && n < MAX_RESULTS; idx++) begin
            if (!(store[idx] < value || (incl && store[idx] == value))) break;
            push_beat(STATUS_OK, store[idx], 1'b1, 1'b0);
            n++;
          end
          values_out += n;
          if (n == 0) push_beat(STATUS_OK, '0, 1'b0, 1'b1);
          else awaited[awaited.size()-1].is_last = 1'b1;
        end
        default: begin
          // spare codes change nothing
          push_beat(STATUS_OK, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void report(string field, slc_value_t exp_v, slc_value_t got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    endfunction

    // compare one accepted beat with the oldest awaited one
    function void check_result(slc_result_t got);
      slc_result_t want;
      beats++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got status %0d value %0d",
                 $time, got.status, got.item_value);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report("status", slc_value_t'(want.status), slc_value_t'(got.status));
      if (got.item_value !== want.item_value)
        report("item_value", want.item_value, got.item_value);
      if (got.has_item !== want.has_item)
        report("has_item", slc_value_t'(want.has_item), slc_value_t'(got.has_item));
      if (got.entry_count !== want.entry_count)
        report("entry_count", slc_value_t'(want.entry_count),
               slc_value_t'(got.entry_count));
      if (got.is_last !== want.is_last)
        report("is_last", slc_value_t'(want.is_last), slc_value_t'(got.is_last));
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
// tb_top: self-checking bench for sorted_list_engine, directed then random commands
// depends on slc_pkg, slc_cmd_if, slc_res_if, slc_tb_pkg and the engine itself
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;
  import slc_tb_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  // codes the engine treats as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam slc_value_t VAL_MIN = 32'sh8000_0000;
  localparam slc_value_t VAL_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;
  bit   no_idle = 1'b0;
  int   res_hold = 0;
  int   cycles = 0;

  slc_scoreboard sb;

  slc_cmd_if cmd ();
  slc_res_if res ();

  sorted_list_engine #(.CAPACITY(CAPACITY_DEF)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycles, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // note every accepted command beat
  always @(posedge clk_i) begin
    if (rst_ni && cmd.valid && cmd.ready)
      sb.note_command(cmd.kind, cmd.operand_value, cmd.include_limit);
  end

  // result sink: check accepted beats, stall at random after each one
  always @(posedge clk_i) begin
    slc_result_t got;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got.status      = res.status;
        got.item_value  = res.item_value;
        got.has_item    = res.has_item;
        got.entry_count = res.entry_count;
        got.is_last     = res.is_last;
        sb.check_result(got);
        res_hold = no_idle ? 0 : $urandom_range(0, 5);
      end
      res.ready <= (res_hold == 0);
      if (res_hold > 0) res_hold--;
    end
  end

  // one command beat, after a random gap
  task automatic send_command(logic [KIND_W-1:0] kind, slc_value_t value, logic incl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid         <= 1'b1;
    cmd.kind          <= kind;
    cmd.operand_value <= value;
    cmd.include_limit <= incl;
    do @(posedge clk_i); while (!cmd.ready);
  endtask

  // operand mix: small clustered values for duplicates, stored values, extremes, noise
  function automatic slc_value_t pick_value();
    int         sel;
    slc_value_t v;
    sel = $urandom_range(0, 9);
    if (sel < 4) v = slc_value_t'($urandom_range(0, 8)) - 4;
    else if (sel < 7 && sb.store.size() > 0)
      v = sb.store[$urandom_range(0, sb.store.size() - 1)];
    else if (sel == 7) v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    else v = slc_value_t'($urandom);
    return v;
  endfunction

  initial begin
    int               phase;
    int               roll;
    logic [KIND_W-1:0] kind;
    slc_value_t       value;
    logic             incl;

    sb = new(CAPACITY_DEF);
    rst_ni            = 1'b0;
    cmd.valid         = 1'b0;
    cmd.kind          = KIND_INSERT;
    cmd.operand_value = '0;
    cmd.include_limit = 1'b0;
    res.ready         = 1'b0;
    phase             = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store: empty read-out, misses on both removes
    send_command(KIND_READOUT, 0, 1'b1);
    send_command(KIND_REMOVE_ONE, 5, 1'b0);
    send_command(KIND_REMOVE_ALL, 5, 1'b0);
    // extremes and duplicates
    send_command(KIND_INSERT, VAL_MIN, 1'b0);
    send_command(KIND_INSERT, VAL_MAX, 1'b0);
    send_command(KIND_INSERT, 0, 1'b0);
    send_command(KIND_INSERT, 0, 1'b0);
    send_command(KIND_INSERT, -1, 1'b0);
    send_command(KIND_INSERT, VAL_MAX, 1'b0);
    // read-outs: everything, exclusive, inclusive, nothing below the minimum
    send_command(KIND_READOUT, VAL_MAX, 1'b1);
    send_command(KIND_READOUT, 0, 1'b0);
    send_command(KIND_READOUT, 0, 1'b1);
    send_command(KIND_READOUT, VAL_MIN, 1'b0);
    // remove-all in the middle, of the trailing pair, then of a lone value
    send_command(KIND_REMOVE_ALL, 0, 1'b0);
    send_command(KIND_REMOVE_ALL, VAL_MAX, 1'b0);
    send_command(KIND_REMOVE_ONE, VAL_MIN, 1'b0);
    send_command(KIND_REMOVE_ALL, -1, 1'b0);
    // spare codes, clear, then read the empty store
    send_command(KIND_INSERT, 7, 1'b1);
    send_command(KIND_SPARE_5, -1, 1'b1);
    send_command(KIND_SPARE_6, 0, 1'b0);
    send_command(KIND_SPARE_7, VAL_MAX, 1'b1);
    send_command(KIND_CLEAR, VAL_MIN, 1'b1);
    send_command(KIND_READOUT, VAL_MAX, 1'b1);

    // random phases: filling, mixed, draining; some with no idling at all
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        phase   = (i == 0) ? 0 : $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (phase)
        0: kind = roll < 70 ? KIND_INSERT : roll < 78 ? KIND_REMOVE_ONE :
                  roll < 82 ? KIND_REMOVE_ALL : roll < 95 ? KIND_READOUT :
                  roll < 96 ? KIND_CLEAR : KIND_SPARE_5;
        1: kind = roll < 40 ? KIND_INSERT : roll < 55 ? KIND_REMOVE_ONE :
                  roll < 65 ? KIND_REMOVE_ALL : roll < 90 ? KIND_READOUT :
                  roll < 94 ? KIND_CLEAR : KIND_SPARE_6;
        default: kind = roll < 25 ? KIND_INSERT : roll < 50 ? KIND_REMOVE_ONE :
                        roll < 65 ? KIND_REMOVE_ALL : roll < 92 ? KIND_READOUT :
                        roll < 94 ? KIND_CLEAR : KIND_SPARE_7;
      endcase
      value = pick_value();
      incl  = 1'($urandom_range(0, 1));
      // full read-out now and then
      if (kind == KIND_READOUT && $urandom_range(0, 7) == 0) begin
        value = VAL_MAX;
        incl  = 1'b1;
      end
      send_command(kind, value, incl);
    end
    cmd.valid <= 1'b0;
    no_idle = 1'b0;

    // let the last command beat register, then drain
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d commands giving %0d result beats, %0d of them stored values",
             sb.commands, sb.beats, sb.values_out);
    $display("inserts dropped on a full store: %0d, removes of absent values: %0d",
             sb.full_drops, sb.misses);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
